// ===== hw/rtl/per_line_substring_counter_top_macros.svh =====
`ifndef PER_LINE_SUBSTRING_COUNTER_TOP_MACROS_SVH
`define PER_LINE_SUBSTRING_COUNTER_TOP_MACROS_SVH

// same-cycle implication, checked on i_clk outside reset
`define PLC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on i_clk outside reset
`define PLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/plc_pkg.sv =====
package plc_pkg;

    localparam int OP_W  = 2;
    localparam int CFG_W = 2;
    localparam int LEN_W = 5;

    localparam logic [OP_W-1:0] OP_CHAR = 2'd0;
    localparam logic [OP_W-1:0] OP_EOL  = 2'd1;
    localparam logic [OP_W-1:0] OP_EOT  = 2'd2;

    localparam logic [CFG_W-1:0] CFG_PAT_LO  = 2'd0;
    localparam logic [CFG_W-1:0] CFG_PAT_HI  = 2'd1;
    localparam logic [CFG_W-1:0] CFG_PAT_LEN = 2'd2;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/plc_cell.sv =====
module plc_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  plc_pkg::t_cell_ctl i_ctl,
    input  logic              i_prev,
    input  logic [7:0]        i_char,
    input  logic [7:0]        i_pat_byte,
    input  logic              i_active,
    input  logic              i_last,
    output logic              o_match,
    output logic              o_hit
);
    import plc_pkg::*;

    logic r_match;
    logic n_match;

    assign n_match = i_prev & i_active & (i_char == i_pat_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_match <= 1'b0;
        end else if (i_ctl.shift) begin
            r_match <= n_match;
        end
    end

    assign o_match = r_match;
    assign o_hit   = i_ctl.shift & i_last & n_match;

endmodule

// ===== hw/rtl/per_line_substring_counter_top.sv =====
// Per-line substring counter.
// Input channel (i_in_valid / o_in_stall): one item per accepted edge, i_op selects
// a text byte (i_char_byte), an end of line or an end of text; op 3 is ignored.
// Output channel (o_out_valid / i_out_stall): one item per matching line with its
// report number, line number and hit count, or a no_match item at end of text
// when no line of the text matched.
// Throughput is one item per cycle while o_in_stall is low: a row of PATTERN_MAX match
// cells, one per pattern byte, updates the partial matches for each accepted byte.
// A result is formed combinationally from the item that causes it and registered in the output register.
// When the receiver stalls, one further result is held in a skid register;
// o_in_stall rises only while that skid register is full.
// Reset clears the pattern registers, counters, match cells and the valid flags of both buffers.
// Configuration is to be written through i_cfg_we / i_cfg_index / i_cfg_data only
// while the block is idle; the block itself does not enforce this.
module per_line_substring_counter_top #(
    parameter int PATTERN_MAX = 16,
    parameter int HIT_BITS    = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [plc_pkg::OP_W-1:0]  i_op,
    input  logic [7:0]                i_char_byte,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [31:0]               o_report_number,
    output logic [31:0]               o_line_number,
    output logic [HIT_BITS-1:0]       o_hits,
    output logic                      o_no_match,
    input  logic                      i_cfg_we,
    input  logic [plc_pkg::CFG_W-1:0] i_cfg_index,
    input  logic [63:0]               i_cfg_data
);
    import plc_pkg::*;

    logic [63:0]      r_pat_lo;
    logic [63:0]      r_pat_hi;
    logic [LEN_W-1:0] r_pat_len;
    logic [LEN_W-1:0] w_used_len;

    logic [31:0]         r_line_cnt;
    logic [31:0]         r_reports;
    logic [HIT_BITS-1:0] r_hit_cnt;
    logic                r_line_open;

    logic                r_out_valid;
    logic [31:0]         r_out_rep;
    logic [31:0]         r_out_line;
    logic [HIT_BITS-1:0] r_out_hits;
    logic                r_out_nm;
    logic                r_skd_valid;
    logic [31:0]         r_skd_rep;
    logic [31:0]         r_skd_line;
    logic [HIT_BITS-1:0] r_skd_hits;
    logic                r_skd_nm;

    logic w_acc, w_char, w_eol, w_eot, w_close, w_report, w_nomatch, w_res_valid;
    logic w_hit, w_drain;
    logic [31:0]         w_line_inc;
    logic [31:0]         w_rep_inc;
    logic [31:0]         w_res_rep;
    logic [31:0]         w_res_line;
    logic [HIT_BITS-1:0] w_res_hits;
    t_cell_ctl           w_ctl;

    logic [PATTERN_MAX:0]   w_match;
    logic [PATTERN_MAX-1:0] w_hits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PAT_LO:  r_pat_lo  <= i_cfg_data;
                CFG_PAT_HI:  r_pat_hi  <= i_cfg_data;
                CFG_PAT_LEN: r_pat_len <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_used_len = (r_pat_len > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : r_pat_len;

    assign o_in_stall = r_skd_valid;
    assign w_acc      = i_in_valid && !r_skd_valid;
    assign w_char     = w_acc && (i_op == OP_CHAR);
    assign w_eol      = w_acc && (i_op == OP_EOL);
    assign w_eot      = w_acc && (i_op == OP_EOT);

    assign w_ctl.shift = w_char;
    assign w_ctl.clear = w_eol || w_eot;

    assign w_match[0] = 1'b1;

    for (genvar gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
        logic [7:0] w_pat_byte;
        if (gi < 8) begin : g_lo
            assign w_pat_byte = r_pat_lo[8*gi +: 8];
        end else begin : g_hi
            assign w_pat_byte = r_pat_hi[8*(gi-8) +: 8];
        end
        plc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_prev     (w_match[gi]),
            .i_char     (i_char_byte),
            .i_pat_byte (w_pat_byte),
            .i_active   (LEN_W'(gi) < w_used_len),
            .i_last     (LEN_W'(gi + 1) == w_used_len),
            .o_match    (w_match[gi+1]),
            .o_hit      (w_hits[gi])
        );
    end

    assign w_hit = |w_hits;

    assign w_line_inc = (r_line_cnt == '1) ? r_line_cnt : r_line_cnt + 32'd1;
    assign w_rep_inc  = (r_reports == '1) ? r_reports : r_reports + 32'd1;

    assign w_close     = w_eol || (w_eot && r_line_open);
    assign w_report    = w_close && (r_hit_cnt != '0);
    assign w_nomatch   = w_eot && !w_report && (r_reports == '0);
    assign w_res_valid = w_report || w_nomatch;
    assign w_res_rep   = w_report ? w_rep_inc : '0;
    assign w_res_line  = w_report ? w_line_inc : '0;
    assign w_res_hits  = w_report ? r_hit_cnt : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_cnt  <= '0;
            r_reports   <= '0;
            r_hit_cnt   <= '0;
            r_line_open <= 1'b0;
        end else if (w_eot) begin
            r_line_cnt  <= '0;
            r_reports   <= '0;
            r_hit_cnt   <= '0;
            r_line_open <= 1'b0;
        end else if (w_eol) begin
            r_line_cnt  <= w_line_inc;
            r_hit_cnt   <= '0;
            r_line_open <= 1'b0;
            if (w_report) begin
                r_reports <= w_rep_inc;
            end
        end else if (w_char) begin
            r_line_open <= 1'b1;
            if (w_hit && (r_hit_cnt != '1)) begin
                r_hit_cnt <= r_hit_cnt + HIT_BITS'(1);
            end
        end
    end

    assign w_drain = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (r_skd_valid) begin
            if (w_drain) begin
                r_out_valid <= 1'b1;
                r_skd_valid <= 1'b0;
            end
        end else if (w_res_valid) begin
            if (r_out_valid && !w_drain) begin
                r_skd_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_drain) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_valid) begin
            if (w_drain) begin
                r_out_rep  <= r_skd_rep;
                r_out_line <= r_skd_line;
                r_out_hits <= r_skd_hits;
                r_out_nm   <= r_skd_nm;
            end
        end else if (w_res_valid) begin
            if (r_out_valid && !w_drain) begin
                r_skd_rep  <= w_res_rep;
                r_skd_line <= w_res_line;
                r_skd_hits <= w_res_hits;
                r_skd_nm   <= w_nomatch;
            end else begin
                r_out_rep  <= w_res_rep;
                r_out_line <= w_res_line;
                r_out_hits <= w_res_hits;
                r_out_nm   <= w_nomatch;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_report_number = r_out_rep;
    assign o_line_number   = r_out_line;
    assign o_hits          = r_out_hits;
    assign o_no_match      = r_out_nm;

endmodule

// ===== hw/rtl/plc_checker.sv =====
`include "per_line_substring_counter_top_macros.svh"

module plc_checker #(
    parameter int HIT_BITS = 12
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [31:0]         o_report_number,
    input logic [31:0]         o_line_number,
    input logic [HIT_BITS-1:0] o_hits,
    input logic                o_no_match
);

    `PLC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_report_number) && $stable(o_line_number)
        && $stable(o_hits) && $stable(o_no_match), "stalled output item changed")

    `PLC_ASSERT_NOW(a_nomatch_zero, o_out_valid && o_no_match,
        o_report_number == '0 && o_line_number == '0 && o_hits == '0,
        "no_match item carries nonzero fields")

    `PLC_ASSERT_NOW(a_report_nonzero, o_out_valid && !o_no_match,
        o_report_number != '0 && o_line_number != '0 && o_hits != '0,
        "line report with a zero field")

    `PLC_ASSERT_NOW(a_stall_pending, o_in_stall, o_out_valid,
        "input stalled with no output item pending")

endmodule

bind per_line_substring_counter_top plc_checker #(.HIT_BITS(HIT_BITS)) u_plc_checker (.*);
